// File: rtl/core/srh_pkg.sv
// ----------------------------------------------------------------------------
// srh_pkg: shared types for the sequential read-ahead hinter
// Configuration indexes, reset values, and the structs that carry state,
// configuration and hint results between the top level and the datapath.
// ----------------------------------------------------------------------------
package srh_pkg;

    typedef enum logic [1:0] {
        CFG_MIN_LENGTH  = 2'd0,
        CFG_WINDOW      = 2'd1,
        CFG_LOW_WATER   = 2'd2,
        CFG_UNUSED      = 2'd3
    } srh_cfg_idx_t;

    localparam logic [31:0] MIN_LENGTH_RST = 32'd65536;
    localparam logic [31:0] WINDOW_RST     = 32'd4194304;
    localparam logic [31:0] LOW_WATER_RST  = 32'd1048576;

    typedef struct packed {
        logic [31:0] min_length;
        logic [31:0] window_bytes;
        logic [31:0] low_water_bytes;
    } srh_cfg_t;

    // first set means no read has been seen yet (last end of minus one)
    typedef struct packed {
        logic        first;
        logic [62:0] last_end;
        logic [62:0] ahead_end;
    } srh_state_t;

    typedef struct packed {
        logic        valid;
        logic [62:0] start;
        logic [62:0] length;
    } srh_hint_t;

endpackage

// File: rtl/core/srh_calc.sv
// ----------------------------------------------------------------------------
// srh_calc: request evaluation datapath
// Validates one read request, classifies it as sequential or not, and forms
// the hint range and the next stream state in a single combinational pass.
// ----------------------------------------------------------------------------
module srh_calc
(
    input  logic                stream_open,
    input  logic signed [63:0]  req_offset,
    input  logic [31:0]         req_length,
    input  logic [62:0]         total_size,
    input  srh_pkg::srh_cfg_t   cfg,
    input  srh_pkg::srh_state_t state,
    output srh_pkg::srh_hint_t  hint,
    output srh_pkg::srh_state_t state_next
);

    logic [62:0] off;
    logic [63:0] req_sum;
    logic        size_known;
    logic [62:0] end_clip;
    logic        reject;
    logic        seq;
    logic [63:0] lw_sum;
    logic [62:0] lw_end;
    logic        skip;
    logic [63:0] win_sum;
    logic [62:0] win_end;
    logic [62:0] he_seq;
    logic [62:0] hs;
    logic [62:0] he;
    logic        has_range;
    logic [62:0] hl;
    logic        emit;

    always_comb
    begin
        off        = req_offset[62:0];
        req_sum    = {1'b0, off} + {32'b0, req_length};
        size_known = (total_size != 63'd0);
        end_clip   = (size_known && (req_sum[62:0] > total_size)) ? total_size
                                                                  : req_sum[62:0];

        reject = !stream_open || req_offset[63] || (req_length < cfg.min_length) ||
                 req_sum[63] || (end_clip <= off);

        seq = state.first || (off == state.last_end);

        // saturating adds at the maximum offset
        lw_sum  = {1'b0, end_clip} + {32'b0, cfg.low_water_bytes};
        lw_end  = lw_sum[63] ? {63{1'b1}} : lw_sum[62:0];
        win_sum = {1'b0, end_clip} + {32'b0, cfg.window_bytes};
        win_end = win_sum[63] ? {63{1'b1}} : win_sum[62:0];

        skip   = seq && (state.ahead_end > lw_end);
        he_seq = (size_known && (win_end > total_size)) ? total_size : win_end;

        if (seq)
        begin
            hs = (state.ahead_end > off) ? state.ahead_end : off;
            he = he_seq;
        end
        else
        begin
            hs = off;
            he = end_clip;
        end

        has_range = (he > hs);
        hl        = he - hs;
        emit      = !reject && !skip && has_range && (hl >= {31'b0, cfg.min_length});

        hint.valid  = emit;
        hint.start  = emit ? hs : 63'd0;
        hint.length = emit ? hl : 63'd0;

        state_next = state;
        if (!reject)
        begin
            state_next.first    = 1'b0;
            state_next.last_end = end_clip;
            if (!skip)
            begin
                if (has_range)
                    state_next.ahead_end = he;
                else if (!seq)
                    state_next.ahead_end = 63'd0;
            end
        end
    end

endmodule

// File: rtl/core/sequential_readahead_hinter.sv
// ----------------------------------------------------------------------------
// sequential_readahead_hinter: single-stream read-ahead hint generator
// Takes read requests, tracks the stream position and read-ahead end, and
// returns one hint result per request.
// ----------------------------------------------------------------------------
// One request is accepted per clock while the output is not stalled, and each
// produces exactly one result beat: the request is captured in an input
// register, evaluated against the stream state in one combinational pass, and
// the result lands in an output register while the state updates at the same
// edge. Throughput is set by that one evaluation stage, which closes the loop
// on the stream state every cycle that the output does not stall. Stall on the
// output backs up into the input register and then onto the input channel.
// Reset starts a fresh stream; reset again for a new file. Configuration
// writes are always taken and should be issued only while no request is in
// flight.
module sequential_readahead_hinter
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               in_valid,
    output logic               in_stall,
    input  logic               stream_open,
    input  logic signed [63:0] req_offset,
    input  logic [31:0]        req_length,
    input  logic [62:0]        total_size,

    output logic               out_valid,
    input  logic               out_stall,
    output logic               hint_valid,
    output logic [62:0]        hint_offset,
    output logic [62:0]        hint_length,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    srh_pkg::srh_cfg_t   cfg_reg;
    srh_pkg::srh_state_t state_reg;
    srh_pkg::srh_state_t state_next;
    srh_pkg::srh_hint_t  hint_next;
    srh_pkg::srh_hint_t  hint_reg;

    logic               s1_valid_reg;
    logic               s1_open_reg;
    logic signed [63:0] s1_offset_reg;
    logic [31:0]        s1_length_reg;
    logic [62:0]        s1_size_reg;
    logic               out_valid_reg;

    logic advance;
    logic fire;
    logic in_take;

    assign advance  = !out_valid_reg || !out_stall;
    assign fire     = s1_valid_reg && advance;
    assign in_stall = s1_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_length      <= srh_pkg::MIN_LENGTH_RST;
            cfg_reg.window_bytes    <= srh_pkg::WINDOW_RST;
            cfg_reg.low_water_bytes <= srh_pkg::LOW_WATER_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (srh_pkg::srh_cfg_idx_t'(cfg_index))
                srh_pkg::CFG_MIN_LENGTH: cfg_reg.min_length      <= cfg_data;
                srh_pkg::CFG_WINDOW:     cfg_reg.window_bytes    <= cfg_data;
                srh_pkg::CFG_LOW_WATER:  cfg_reg.low_water_bytes <= cfg_data;
                default:                 ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_take)
            s1_valid_reg <= 1'b1;
        else if (fire)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_open_reg   <= stream_open;
            s1_offset_reg <= req_offset;
            s1_length_reg <= req_length;
            s1_size_reg   <= total_size;
        end
    end

    srh_calc u_calc
    (
        .stream_open (s1_open_reg),
        .req_offset  (s1_offset_reg),
        .req_length  (s1_length_reg),
        .total_size  (s1_size_reg),
        .cfg         (cfg_reg),
        .state       (state_reg),
        .hint        (hint_next),
        .state_next  (state_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.first     <= 1'b1;
            state_reg.last_end  <= {63{1'b1}};
            state_reg.ahead_end <= 63'd0;
        end
        else if (fire)
        begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            hint_reg <= hint_next;
    end

    assign out_valid   = out_valid_reg;
    assign hint_valid  = hint_reg.valid;
    assign hint_offset = hint_reg.start;
    assign hint_length = hint_reg.length;

    logic [63:0] hint_span;
    assign hint_span = {1'b0, hint_reg.start} + {1'b0, hint_reg.length};

    a_empty_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> !in_stall)
        else $error("input stalled with empty input register");

    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(state_reg))
        else $error("stream state changed without a request");

    a_no_hint_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !hint_reg.valid) |->
            (hint_reg.start == 63'd0 && hint_reg.length == 63'd0))
        else $error("nonzero range on a beat without a hint");

    a_hint_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && hint_reg.valid) |->
            (hint_reg.length != 63'd0 && !hint_span[63]))
        else $error("hint range empty or past maximum offset");

    a_fire_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg)
        else $error("evaluated request produced no result beat");

endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the sequential read-ahead hinter
// Drives read requests with random bursts and gaps while the result side
// stalls on its own pattern. The expected hint for each request is computed
// when the request is taken, and each result beat is checked against it in
// order. Covers directed corner cases, register extremes and random streams.
// ----------------------------------------------------------------------------
module tb_top;

    localparam logic [63:0] OFF_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MB      = 64'd1048576;

    logic                  clk;
    logic                  rst_n       = 1'b0;
    logic                  in_valid    = 1'b0;
    logic                  in_stall;
    logic                  stream_open = 1'b0;
    logic signed [63:0]    req_offset  = '0;
    logic [31:0]           req_length  = '0;
    logic [62:0]           total_size  = '0;
    logic                  out_valid;
    logic                  out_stall   = 1'b0;
    logic                  hint_valid;
    logic [62:0]           hint_offset;
    logic [62:0]           hint_length;
    logic                  cfg_valid   = 1'b0;
    logic                  cfg_ready;
    srh_pkg::srh_cfg_idx_t cfg_index   = srh_pkg::CFG_MIN_LENGTH;
    logic [31:0]           cfg_data    = '0;

    // mirror of the block's registers and stream position
    srh_pkg::srh_cfg_t   hint_cfg;
    srh_pkg::srh_state_t stream_st;

    srh_pkg::srh_hint_t  pending_hints[$];
    int                  err_count   = 0;
    int                  burst_left  = 0;
    logic                sender_gaps = 1'b1;

    sequential_readahead_hinter dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .stream_open (stream_open),
        .req_offset  (req_offset),
        .req_length  (req_length),
        .total_size  (total_size),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .hint_valid  (hint_valid),
        .hint_offset (hint_offset),
        .hint_length (hint_length),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [31:0] b);
        if (a > OFF_MAX - {32'b0, b})
            return OFF_MAX;
        return a + {32'b0, b};
    endfunction

    // advances the stream mirror and returns the hint this request yields
    function automatic srh_pkg::srh_hint_t predict_hint(input logic open,
                                                        input logic [63:0] off,
                                                        input logic [31:0] len,
                                                        input logic [62:0] size);
        srh_pkg::srh_hint_t h;
        logic [63:0] size64;
        logic [63:0] end_pos;
        logic [63:0] lw_end;
        logic [63:0] hs;
        logic [63:0] he;
        logic [63:0] hl;
        logic        seq;
        h = '0;
        size64 = {1'b0, size};
        if (!open || off[63] || len < hint_cfg.min_length)
            return h;
        if ({32'b0, len} > OFF_MAX - off)
            return h;
        end_pos = off + {32'b0, len};
        if (size64 != 0 && end_pos > size64)
            end_pos = size64;
        if (end_pos <= off)
            return h;
        seq = stream_st.first || off == {1'b0, stream_st.last_end};
        if (seq)
        begin
            lw_end = sat_add(end_pos, hint_cfg.low_water_bytes);
            if ({1'b0, stream_st.ahead_end} > lw_end)
            begin
                // read-ahead still well ahead: only the position moves
                stream_st.last_end = end_pos[62:0];
                stream_st.first = 1'b0;
                return h;
            end
            hs = ({1'b0, stream_st.ahead_end} > off) ? {1'b0, stream_st.ahead_end} : off;
            he = sat_add(end_pos, hint_cfg.window_bytes);
            if (size64 != 0 && he > size64)
                he = size64;
        end
        else
        begin
            stream_st.ahead_end = '0;
            hs = off;
            he = end_pos;
        end
        if (he > hs)
        begin
            hl = he - hs;
            if (hl >= {32'b0, hint_cfg.min_length})
            begin
                h.valid = 1'b1;
                h.start = hs[62:0];
                h.length = hl[62:0];
            end
            // ahead end moves even when the hint is too short to emit
            stream_st.ahead_end = he[62:0];
        end
        stream_st.last_end = end_pos[62:0];
        stream_st.first = 1'b0;
        return h;
    endfunction

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        if (err_count < 40)
            $display("%0t: %s mismatch, got %h expected %h", $time, what, got, want);
        err_count++;
    endtask

    task automatic send_req(input logic open, input logic [63:0] off,
                            input logic [31:0] len, input logic [62:0] size);
        in_valid    <= 1'b1;
        stream_open <= open;
        req_offset  <= off;
        req_length  <= len;
        total_size  <= size;
        do
            @(posedge clk);
        while (in_stall);
        pending_hints.push_back(predict_hint(open, off, len, size));
        if (burst_left > 0)
            burst_left--;
        else if (sender_gaps)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(0, 24);
        end
    endtask

    // leaves valid high; the caller drops it after the last write
    task automatic write_reg(input srh_pkg::srh_cfg_idx_t idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            srh_pkg::CFG_MIN_LENGTH: hint_cfg.min_length = data;
            srh_pkg::CFG_WINDOW:     hint_cfg.window_bytes = data;
            srh_pkg::CFG_LOW_WATER:  hint_cfg.low_water_bytes = data;
            default:                 ;
        endcase
    endtask

    task automatic set_config(input logic [31:0] min_len, input logic [31:0] window,
                              input logic [31:0] low_water);
        write_reg(srh_pkg::CFG_MIN_LENGTH, min_len);
        write_reg(srh_pkg::CFG_WINDOW, window);
        write_reg(srh_pkg::CFG_LOW_WATER, low_water);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain_hints();
        in_valid <= 1'b0;
        while (pending_hints.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_len();
        case ($urandom_range(0, 5))
            0:       return hint_cfg.min_length;
            1:       return $urandom_range(0, 32'h0010_0000);
            2:       return $urandom_range(0, 32'h0400_0000);
            3:       return $urandom;
            4:       return hint_cfg.min_length - 32'd1;
            default: return $urandom_range(32'h0001_0000, 32'h0020_0000);
        endcase
    endfunction

    // receiver stall pattern: quiet, light, heavy and periodic stretches
    initial
    begin : out_stall_gen
        int mode;
        int left;
        mode = 0;
        left = 0;
        forever
        begin
            @(posedge clk);
            if (left == 0)
            begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(20, 150);
            end
            left--;
            case (mode)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 3) == 0);
                2:       out_stall <= ($urandom_range(0, 9) < 7);
                default: out_stall <= ((left % 5) < 2);
            endcase
        end
    end

    always @(posedge clk)
    begin : hint_check
        srh_pkg::srh_hint_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_hints.size() == 0)
                flag_mismatch("unexpected beat", {1'b0, hint_offset}, '0);
            else
            begin
                want = pending_hints.pop_front();
                if (hint_valid !== want.valid)
                    flag_mismatch("hint_valid", {63'b0, hint_valid}, {63'b0, want.valid});
                if (hint_offset !== want.start)
                    flag_mismatch("hint_offset", {1'b0, hint_offset}, {1'b0, want.start});
                if (hint_length !== want.length)
                    flag_mismatch("hint_length", {1'b0, hint_length}, {1'b0, want.length});
            end
        end
    end

    // reset register values: min 64K, window 4M, low water 1M
    task automatic test_directed_defaults();
        send_req(1'b0, 64'd0, 32'd1048576, 63'd0);                 // closed stream
        send_req(1'b1, 64'hFFFF_FFFF_FFFF_0000, 32'd1048576, 63'd0); // negative offset
        send_req(1'b1, 64'd0, 32'd65535, 63'd0);                   // below min length
        send_req(1'b1, OFF_MAX - 64'd100, 32'd1048576, 63'd0);     // passes max offset
        send_req(1'b1, 10 * MB, 32'd1048576, 63'(10 * MB));        // empty after clipping
        send_req(1'b1, 64'd0, 32'd1048576, 63'd0);                 // first read
        send_req(1'b1, MB, 32'd65536, 63'd0);                      // read-ahead far ahead
        send_req(1'b1, MB + 64'd65536, 32'd4194304, 63'd0);        // sequential, hint again
        send_req(1'b0, 64'd5308416, 32'd65536, 63'd0);             // closed on the stream
        send_req(1'b1, 100 * MB, 32'd131072, 63'd0);               // jump: own range
        send_req(1'b1, 100 * MB + 64'd131072, 32'd1048576, 63'(100 * MB + 64'd524288));
        send_req(1'b1, 200 * MB, 32'd1048576, 63'(200 * MB + 64'd1000)); // short hint
        send_req(1'b1, OFF_MAX - 2 * MB, 32'd1048576, 63'd0);
        send_req(1'b1, OFF_MAX - MB, 32'd524288, 63'd0);           // saturating window
        send_req(1'b1, 64'd0, 32'hFFFF_FFFF, 63'd0);
        send_req(1'b1, 64'h0000_0000_FFFF_FFFF, 32'd1048576, 63'h7FFF_FFFF_FFFF_FFFF);
        send_req(1'b1, OFF_MAX, 32'd65536, 63'd0);
    endtask

    task automatic test_config_extremes();
        write_reg(srh_pkg::CFG_UNUSED, 32'h1234_5678);   // must be ignored
        set_config(32'd0, 32'd0, 32'd0);
        send_req(1'b1, 64'd1000, 32'd0, 63'd0);
        send_req(1'b1, 64'd1000, 32'd1, 63'd0);
        send_req(1'b1, 64'd1001, 32'd10, 63'd0);
        send_req(1'b1, 64'd1011, 32'd5, 63'd1013);
        drain_hints();
        set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_req(1'b1, 64'd0, 32'hFFFF_FFFF, 63'd0);
        send_req(1'b1, 64'h0000_0000_FFFF_FFFF, 32'hFFFF_FFFF, 63'd0);
        send_req(1'b1, 64'h0000_0001_FFFF_FFFE, 32'hFFFF_FFFE, 63'd0);
        send_req(1'b1, OFF_MAX - 64'h0000_0000_FFFF_FFFF, 32'hFFFF_FFFF, 63'd0);
        drain_hints();
    endtask

    task automatic test_random_streams();
        int          p;
        int          i;
        int          kind;
        int          run_left;
        logic        run_first;
        logic        open;
        logic [63:0] run_base;
        logic [63:0] rnd64;
        logic [63:0] off;
        logic [62:0] run_size;
        logic [62:0] size;
        logic [31:0] len;
        for (p = 0; p < 5; p++)
        begin
            case (p)
                0: set_config(srh_pkg::MIN_LENGTH_RST, srh_pkg::WINDOW_RST,
                              srh_pkg::LOW_WATER_RST);
                1: set_config(32'd0, 32'd0, 32'd0);
                2: set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
                default: set_config($urandom_range(0, 32'h0004_0000),
                                    $urandom_range(0, 32'h0100_0000),
                                    $urandom_range(0, 32'h0080_0000));
            endcase
            sender_gaps = (p != 1);
            run_left = 0;
            run_first = 1'b1;
            run_base = '0;
            run_size = '0;
            for (i = 0; i < 170; i++)
            begin
                if (run_left == 0)
                begin
                    run_left = $urandom_range(3, 30);
                    run_first = 1'b1;
                    rnd64 = {$urandom, $urandom};
                    case ($urandom_range(0, 3))
                        0:       run_base = '0;
                        1:       run_base = {32'b0, rnd64[31:0]};
                        2:       run_base = rnd64 & OFF_MAX;
                        default: run_base = OFF_MAX - $urandom_range(0, 32'h0400_0000);
                    endcase
                    rnd64 = {$urandom, $urandom};
                    case ($urandom_range(0, 2))
                        0:       run_size = '0;
                        1:       run_size = run_base[62:0] + $urandom_range(0, 32'h0400_0000);
                        default: run_size = rnd64[62:0];
                    endcase
                end
                run_left--;
                kind = $urandom_range(0, 9);
                rnd64 = {$urandom, $urandom};
                open = 1'b1;
                size = run_size;
                len = pick_len();
                off = run_first ? run_base : {1'b0, stream_st.last_end};
                if (kind == 7)
                    off = run_base + $urandom_range(0, 32'h0100_0000);
                else if (kind == 8)
                begin
                    open = rnd64[0];
                    off = {$urandom, $urandom};
                    len = $urandom;
                    size = rnd64[63:1];
                end
                else if (kind == 9)
                begin
                    case ($urandom_range(0, 2))
                        0:       open = 1'b0;
                        1:       off = {1'b1, rnd64[62:0]};
                        default: len = hint_cfg.min_length - 32'd1;
                    endcase
                end
                else
                    run_first = 1'b0;
                send_req(open, off, len, size);
            end
            drain_hints();
        end
    endtask

    initial
    begin : run_all
        hint_cfg  = '{srh_pkg::MIN_LENGTH_RST, srh_pkg::WINDOW_RST, srh_pkg::LOW_WATER_RST};
        stream_st = '{1'b1, 63'd0, 63'd0};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_defaults();
        drain_hints();
        test_config_extremes();
        test_random_streams();
        drain_hints();
        repeat (10) @(posedge clk);
        if (err_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/srh_pkg.sv
rtl/core/srh_calc.sv
rtl/core/sequential_readahead_hinter.sv
bench/tb_top.sv
